// ----- rtl/vector3_normalize_defines.svh -----
// Assertion macros for the vector normalizer RTL.
`ifndef VECTOR3_NORMALIZE_DEFINES_SVH
`define VECTOR3_NORMALIZE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication check.
`define VN_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication check.
`define VN_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define VN_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define VN_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ----- rtl/vn_pkg.sv -----
`timescale 1ns / 1ps

package vn_pkg;

   // Fraction bits of the input components.
   localparam int IN_FRAC_BITS = 16;

   // Control that travels with each beat through the pipeline.
   typedef struct packed {
      logic       valid;
      logic       zero;
      logic [2:0] neg;
   } vn_ctl_type;

endpackage

// ----- rtl/vn_req_if.sv -----
`timescale 1ns / 1ps

interface vn_req_if #(parameter int W = 32) ();
   logic                valid;
   logic                ready;
   logic signed [W-1:0] comp_x;
   logic signed [W-1:0] comp_y;
   logic signed [W-1:0] comp_z;

   modport source (output valid, output comp_x, output comp_y, output comp_z, input ready);
   modport sink   (input valid, input comp_x, input comp_y, input comp_z, output ready);
endinterface

// ----- rtl/vn_rsp_if.sv -----
`timescale 1ns / 1ps

interface vn_rsp_if #(parameter int F = 30) ();
   logic                valid;
   logic                ready;
   logic signed [F+1:0] unit_x;
   logic signed [F+1:0] unit_y;
   logic signed [F+1:0] unit_z;
   logic                zero_length;

   modport source (output valid, output unit_x, output unit_y, output unit_z,
                   output zero_length, input ready);
   modport sink   (input valid, input unit_x, input unit_y, input unit_z,
                   input zero_length, output ready);
endinterface

// ----- rtl/vn_square.sv -----
`timescale 1ns / 1ps

// Magnitudes, split squares and sum of squares: four register stages.
module vn_square #(
   parameter int W = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [W-1:0]       comp_x,
   input  logic [W-1:0]       comp_y,
   input  logic [W-1:0]       comp_z,
   output vn_pkg::vn_ctl_type ctl_out,
   output logic [2*W-1:0]     sum_out,
   output logic [3*W-1:0]     mag_out
);
   import vn_pkg::*;

   localparam int LO   = W / 2;
   localparam int HI   = W - LO;
   localparam int SQ_W = 2 * W;

   logic [W-1:0] comp_in [3];

   vn_ctl_type ctl1_ff, ctl1_in, ctl2_ff, ctl3_ff, ctl4_ff;
   logic [W-1:0]       mag1_ff [3];
   logic [W-1:0]       mag1_in [3];
   logic [W-1:0]       mag2_ff [3];
   logic [W-1:0]       mag3_ff [3];
   logic [W-1:0]       mag4_ff [3];
   logic [2*LO-1:0]    ll_ff [3];
   logic [2*LO-1:0]    ll_in [3];
   logic [LO+HI-1:0]   lh_ff [3];
   logic [LO+HI-1:0]   lh_in [3];
   logic [2*HI-1:0]    hh_ff [3];
   logic [2*HI-1:0]    hh_in [3];
   logic [SQ_W-1:0]    sq_ff [3];
   logic [SQ_W-1:0]    sq_in [3];
   logic [SQ_W-1:0]    sum_ff, sum_in;

   assign comp_in[0] = comp_x;
   assign comp_in[1] = comp_y;
   assign comp_in[2] = comp_z;

   // stage 1: sign and magnitude, most negative value maps to 2^(W-1)
   always_comb begin
      ctl1_in.valid = in_valid;
      ctl1_in.zero  = (comp_x == '0) && (comp_y == '0) && (comp_z == '0);
      ctl1_in.neg   = {comp_z[W-1], comp_y[W-1], comp_x[W-1]};
      for (int i = 0; i < 3; i++) begin
         mag1_in[i] = comp_in[i][W-1] ? (~comp_in[i] + 1'b1) : comp_in[i];
      end
   end

   // stage 2: partial products of each square
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ll_in[i] = mag1_ff[i][LO-1:0] * mag1_ff[i][LO-1:0];
         lh_in[i] = mag1_ff[i][LO-1:0] * mag1_ff[i][W-1:LO];
         hh_in[i] = mag1_ff[i][W-1:LO] * mag1_ff[i][W-1:LO];
      end
   end

   // stage 3: assemble squares; stage 4: sum them
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = SQ_W'(ll_ff[i]) + (SQ_W'(lh_ff[i]) << (LO + 1))
                  + (SQ_W'(hh_ff[i]) << (2 * LO));
      end
      sum_in = sq_ff[0] + sq_ff[1] + sq_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff.valid <= 1'b0;
         ctl2_ff.valid <= 1'b0;
         ctl3_ff.valid <= 1'b0;
         ctl4_ff.valid <= 1'b0;
      end else if (en) begin
         ctl1_ff <= ctl1_in;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
         ctl4_ff <= ctl3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag1_ff <= mag1_in;
         mag2_ff <= mag1_ff;
         mag3_ff <= mag2_ff;
         mag4_ff <= mag3_ff;
         ll_ff   <= ll_in;
         lh_ff   <= lh_in;
         hh_ff   <= hh_in;
         sq_ff   <= sq_in;
         sum_ff  <= sum_in;
      end
   end

   assign ctl_out = ctl4_ff;
   assign sum_out = sum_ff;
   assign mag_out = {mag4_ff[2], mag4_ff[1], mag4_ff[0]};
endmodule

// ----- rtl/vn_sqrt.sv -----
`timescale 1ns / 1ps

// Pipelined integer square root of sum * 2^32, one root bit per stage.
module vn_sqrt #(
   parameter int W      = 32,
   parameter int SIDE_W = 96
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  vn_pkg::vn_ctl_type                up_ctl,
   input  logic [2*W-1:0]                    up_rad,
   input  logic [SIDE_W-1:0]                 up_side,
   output vn_pkg::vn_ctl_type                dn_ctl,
   output logic [W+vn_pkg::IN_FRAC_BITS-1:0] dn_root,
   output logic [SIDE_W-1:0]                 dn_side
);
   import vn_pkg::*;

   localparam int STEPS  = W + IN_FRAC_BITS;
   localparam int ROOT_W = STEPS;
   localparam int REM_W  = ROOT_W + 2;
   localparam int RAD_W  = 2 * W;

   vn_ctl_type          ctl_s  [0:STEPS-1];
   logic [REM_W-1:0]    rem_s  [0:STEPS-1];
   logic [ROOT_W-1:0]   root_s [0:STEPS-1];
   logic [RAD_W-1:0]    rad_s  [0:STEPS-1];
   logic [SIDE_W-1:0]   side_s [0:STEPS-1];

   vn_ctl_type          ctl_ff  [1:STEPS];
   logic [ROOT_W-1:0]   root_ff [1:STEPS];
   logic [SIDE_W-1:0]   side_ff [1:STEPS];
   logic [REM_W-1:0]    rem_ff  [1:STEPS-1];
   logic [RAD_W-1:0]    rad_ff  [1:STEPS-1];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic [REM_W+1:0]  cur;
      logic [REM_W+1:0]  trial;
      logic              take;
      logic [ROOT_W-1:0] root_in;

      // stage source: the input port or the previous stage
      if (k == 0) begin : g_first
         assign ctl_s[k]  = up_ctl;
         assign rem_s[k]  = '0;
         assign root_s[k] = '0;
         assign rad_s[k]  = up_rad;
         assign side_s[k] = up_side;
      end else begin : g_next
         assign ctl_s[k]  = ctl_ff[k];
         assign rem_s[k]  = rem_ff[k];
         assign root_s[k] = root_ff[k];
         assign rad_s[k]  = rad_ff[k];
         assign side_s[k] = side_ff[k];
      end

      // try root bit: bring down two radicand bits, subtract 4*root+1
      always_comb begin
         cur     = {rem_s[k], rad_s[k][RAD_W-1 -: 2]};
         trial   = {2'b00, root_s[k], 2'b01};
         take    = (cur >= trial);
         root_in = {root_s[k][ROOT_W-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k+1].valid <= 1'b0;
         end else if (en) begin
            ctl_ff[k+1] <= ctl_s[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            root_ff[k+1] <= root_in;
            side_ff[k+1] <= side_s[k];
         end
      end

      if (k < STEPS - 1) begin : g_keep
         logic [REM_W-1:0] rem_in;
         logic [RAD_W-1:0] rad_in;

         always_comb begin
            rem_in = take ? REM_W'(cur - trial) : REM_W'(cur);
            rad_in = rad_s[k] << 2;
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k+1] <= rem_in;
               rad_ff[k+1] <= rad_in;
            end
         end
      end
   end

   assign dn_ctl  = ctl_ff[STEPS];
   assign dn_root = root_ff[STEPS];
   assign dn_side = side_ff[STEPS];
endmodule

// ----- rtl/vn_div.sv -----
`timescale 1ns / 1ps

// Pipelined restoring divider: mag * 2^(16+F) / len, one quotient bit per stage.
// Since len >= mag * 2^16 the quotient never exceeds 2^F.
module vn_div #(
   parameter int W     = 32,
   parameter int F     = 30,
   parameter int TAG_W = 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic [W-1:0]                      mag,
   input  logic [W+vn_pkg::IN_FRAC_BITS-1:0] len,
   input  logic [TAG_W-1:0]                  tag_in,
   output logic                              out_valid,
   output logic [F:0]                        quo,
   output logic [TAG_W-1:0]                  tag_out
);
   import vn_pkg::*;

   localparam int STEPS = F + 1;
   localparam int LEN_W = W + IN_FRAC_BITS;

   logic              valid_s [0:STEPS-1];
   logic [LEN_W-1:0]  rem_s   [0:STEPS-1];
   logic [LEN_W-1:0]  len_s   [0:STEPS-1];
   logic [F:0]        quo_s   [0:STEPS-1];
   logic [TAG_W-1:0]  tag_s   [0:STEPS-1];

   logic              valid_ff [1:STEPS];
   logic [F:0]        quo_ff   [1:STEPS];
   logic [TAG_W-1:0]  tag_ff   [1:STEPS];
   logic [LEN_W-1:0]  rem_ff   [1:STEPS-1];
   logic [LEN_W-1:0]  len_ff   [1:STEPS-1];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic [LEN_W:0] cur;
      logic           take;
      logic [F:0]     quo_in;

      // the numerator's low bits are all zero: the first partial remainder
      // is mag * 2^15 and each step only doubles it
      if (k == 0) begin : g_first
         assign valid_s[k] = in_valid;
         assign rem_s[k]   = {1'b0, mag, {(IN_FRAC_BITS - 1){1'b0}}};
         assign len_s[k]   = len;
         assign quo_s[k]   = '0;
         assign tag_s[k]   = tag_in;
      end else begin : g_next
         assign valid_s[k] = valid_ff[k];
         assign rem_s[k]   = rem_ff[k];
         assign len_s[k]   = len_ff[k];
         assign quo_s[k]   = quo_ff[k];
         assign tag_s[k]   = tag_ff[k];
      end

      always_comb begin
         cur    = {rem_s[k], 1'b0};
         take   = (cur >= {1'b0, len_s[k]});
         quo_in = {quo_s[k][F-1:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (en) begin
            valid_ff[k+1] <= valid_s[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            quo_ff[k+1] <= quo_in;
            tag_ff[k+1] <= tag_s[k];
         end
      end

      if (k < STEPS - 1) begin : g_keep
         logic [LEN_W-1:0] rem_in;

         always_comb begin
            rem_in = take ? LEN_W'(cur - {1'b0, len_s[k]}) : LEN_W'(cur);
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k+1] <= rem_in;
               len_ff[k+1] <= len_s[k];
            end
         end
      end
   end

   assign out_valid = valid_ff[STEPS];
   assign quo       = quo_ff[STEPS];
   assign tag_out   = tag_ff[STEPS];
endmodule

// ----- rtl/vector3_normalize.sv -----
`timescale 1ns / 1ps
`include "vector3_normalize_defines.svh"

// Three-component vector normalizer.
// req_bus carries one vector per beat: comp_x, comp_y, comp_z, signed
// Q(IN_WIDTH-17).16. rsp_bus returns one beat per vector: unit_x, unit_y,
// unit_z in signed Q1.OUT_FRAC_BITS, each within +/- 2^OUT_FRAC_BITS, and
// zero_length, set (with all components zero) for an all-zero input.
// Throughput: one vector per clock, sustained while rsp_bus accepts results.
// Stages from accept to rsp valid: 4 stages of squaring and summing, one
// stage per bit of the length (IN_WIDTH + 16), one stage per quotient bit
// (OUT_FRAC_BITS + 1) in three parallel divider lanes, one output register.
// The whole pipeline advances as one: while a result sits unaccepted on
// rsp_bus, req_bus.ready is low and every stage holds; nothing is dropped
// or repeated. Bubbles travel as invalid beats.
// Reset (synchronous) clears all valid bits; no result is pending after it.
module vector3_normalize #(
   parameter int IN_WIDTH      = 32,
   parameter int OUT_FRAC_BITS = 30
) (
   input logic       clock,
   input logic       reset,
   vn_req_if.sink    req_bus,
   vn_rsp_if.source  rsp_bus
);
   import vn_pkg::*;

   localparam int LEN_W = IN_WIDTH + IN_FRAC_BITS;
   localparam int OUT_W = OUT_FRAC_BITS + 2;
   localparam int Q_W   = OUT_FRAC_BITS + 1;

   logic                  en;
   vn_ctl_type            sq_ctl, rt_ctl;
   logic [2*IN_WIDTH-1:0] sq_sum;
   logic [3*IN_WIDTH-1:0] sq_mag, rt_mag;
   logic [LEN_W-1:0]      rt_len;
   logic [2:0]            lane_valid;
   logic [1:0]            tag_x;
   logic                  tag_y, tag_z;
   logic [Q_W-1:0]        quo_x, quo_y, quo_z;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]      unit_x_ff, unit_x_in;
   logic [OUT_W-1:0]      unit_y_ff, unit_y_in;
   logic [OUT_W-1:0]      unit_z_ff, unit_z_in;
   logic                  zero_ff, zero_in;

   // global advance: move unless a result waits on a stalled receiver
   assign en            = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = en;

   vn_square #(.W(IN_WIDTH)) u_square (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_bus.valid),
      .comp_x   (req_bus.comp_x),
      .comp_y   (req_bus.comp_y),
      .comp_z   (req_bus.comp_z),
      .ctl_out  (sq_ctl),
      .sum_out  (sq_sum),
      .mag_out  (sq_mag)
   );

   vn_sqrt #(.W(IN_WIDTH), .SIDE_W(3 * IN_WIDTH)) u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .up_ctl  (sq_ctl),
      .up_rad  (sq_sum),
      .up_side (sq_mag),
      .dn_ctl  (rt_ctl),
      .dn_root (rt_len),
      .dn_side (rt_mag)
   );

   vn_div #(.W(IN_WIDTH), .F(OUT_FRAC_BITS), .TAG_W(2)) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (rt_ctl.valid),
      .mag       (rt_mag[IN_WIDTH-1:0]),
      .len       (rt_len),
      .tag_in    ({rt_ctl.zero, rt_ctl.neg[0]}),
      .out_valid (lane_valid[0]),
      .quo       (quo_x),
      .tag_out   (tag_x)
   );

   vn_div #(.W(IN_WIDTH), .F(OUT_FRAC_BITS), .TAG_W(1)) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (rt_ctl.valid),
      .mag       (rt_mag[2*IN_WIDTH-1:IN_WIDTH]),
      .len       (rt_len),
      .tag_in    (rt_ctl.neg[1]),
      .out_valid (lane_valid[1]),
      .quo       (quo_y),
      .tag_out   (tag_y)
   );

   vn_div #(.W(IN_WIDTH), .F(OUT_FRAC_BITS), .TAG_W(1)) u_div_z (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (rt_ctl.valid),
      .mag       (rt_mag[3*IN_WIDTH-1:2*IN_WIDTH]),
      .len       (rt_len),
      .tag_in    (rt_ctl.neg[2]),
      .out_valid (lane_valid[2]),
      .quo       (quo_z),
      .tag_out   (tag_z)
   );

   // output stage: restore signs, force zeros for a zero vector
   always_comb begin
      rsp_valid_in = lane_valid[0];
      zero_in      = tag_x[1];
      unit_x_in    = tag_x[0] ? -OUT_W'(quo_x) : OUT_W'(quo_x);
      unit_y_in    = tag_y ? -OUT_W'(quo_y) : OUT_W'(quo_y);
      unit_z_in    = tag_z ? -OUT_W'(quo_z) : OUT_W'(quo_z);
      if (zero_in) begin
         unit_x_in = '0;
         unit_y_in = '0;
         unit_z_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         unit_x_ff <= unit_x_in;
         unit_y_ff <= unit_y_in;
         unit_z_ff <= unit_z_in;
         zero_ff   <= zero_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.unit_x      = unit_x_ff;
   assign rsp_bus.unit_y      = unit_y_ff;
   assign rsp_bus.unit_z      = unit_z_ff;
   assign rsp_bus.zero_length = zero_ff;

   `VN_ASSERT_IMP(a_zero_out, clock, reset, rsp_valid_ff && zero_ff, unit_x_ff == '0 && unit_y_ff == '0 && unit_z_ff == '0, "zero vector produced a nonzero component")
   `VN_ASSERT_IMP(a_lanes_aligned, clock, reset, 1'b1, lane_valid == 3'b000 || lane_valid == 3'b111, "divider lanes out of step")
   `VN_ASSERT_IMP(a_quo_x_bound, clock, reset, lane_valid[0] && !tag_x[1], !quo_x[Q_W-1] || quo_x[Q_W-2:0] == '0, "x quotient above unit")
   `VN_ASSERT_IMP(a_quo_yz_bound, clock, reset, lane_valid[1] && !tag_x[1], (!quo_y[Q_W-1] || quo_y[Q_W-2:0] == '0) && (!quo_z[Q_W-1] || quo_z[Q_W-2:0] == '0), "y or z quotient above unit")
   `VN_ASSERT_NXT(a_stall_holds, clock, reset, !en, $stable(quo_x) && $stable(lane_valid), "pipeline moved during stall")
endmodule
